// ===== hdl/dpd_pkg.sv =====
// Shared constants, register codes and types of the double pulse detector.
package dpd_pkg;

    localparam int WINDOW_DEF      = 20;
    localparam int SAMPLE_BITS_DEF = 12;
    localparam int MAX_SAMPLES_DEF = 4096;

    localparam int THRESHOLD_W = 13;
    localparam int MIN_GAP_W   = 12;
    localparam int CUT_BASE_W  = 12;
    localparam int CUT_STEP_W  = 10;
    localparam int CFG_DATA_W  = 13;
    localparam int CFG_INDEX_W = 2;

    localparam int IDX_W      = 12;
    localparam int HEIGHT_W   = 12;
    localparam int LEVEL_W    = 3;
    localparam int CUT_LEVELS = 5;

    localparam logic [THRESHOLD_W-1:0] THRESHOLD_RST = 13'd40;
    localparam logic [MIN_GAP_W-1:0]   MIN_GAP_RST   = 12'd100;
    localparam logic [CUT_BASE_W-1:0]  CUT_BASE_RST  = 12'd20;
    localparam logic [CUT_STEP_W-1:0]  CUT_STEP_RST  = 10'd5;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_THRESHOLD = 2'd0,
        CFG_MIN_GAP   = 2'd1,
        CFG_CUT_BASE  = 2'd2,
        CFG_CUT_STEP  = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [THRESHOLD_W-1:0] threshold;
        logic [MIN_GAP_W-1:0]   min_gap;
    } judge_cfg_t;

endpackage

// ===== hdl/dpd_sample_if.sv =====
// Sample channel: one signed ADC sample per transaction with an end-of-waveform flag.
interface dpd_sample_if #(
    parameter int SAMPLE_BITS = dpd_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last_sample;

    modport source (output valid, output sample, output last_sample, input ready);
    modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

// ===== hdl/dpd_result_if.sv =====
// Result channel: one pulse-pair report per transaction.
interface dpd_result_if;
    logic                          valid;
    logic                          ready;
    logic                          first_found;
    logic                          second_found;
    logic [dpd_pkg::IDX_W-1:0]     first_index;
    logic [dpd_pkg::IDX_W-1:0]     second_index;
    logic [dpd_pkg::IDX_W-1:0]     gap_samples;
    logic [dpd_pkg::HEIGHT_W-1:0]  first_height;
    logic [dpd_pkg::HEIGHT_W-1:0]  second_height;
    logic [dpd_pkg::LEVEL_W-1:0]   cut_level;

    modport source (output valid, output first_found, output second_found,
                    output first_index, output second_index, output gap_samples,
                    output first_height, output second_height, output cut_level,
                    input ready);
    modport sink   (input valid, input first_found, input second_found,
                    input first_index, input second_index, input gap_samples,
                    input first_height, input second_height, input cut_level,
                    output ready);
endinterface

// ===== hdl/double_pulse_detector.sv =====
// Top level of the double pulse detector: chain of lookahead cells, judge and result register.
//
// Samples of a waveform are taken one per clock cycle while the sample channel is ready. Each
// sample's negated value enters a chain of WINDOW cells; a value leaving the end of the chain
// carries the peak of its own lookahead window and is judged there. After the transaction that
// carries the last sample, the chain is flushed with WINDOW-1 empty slots, a drain state finishes
// the judging and a done state loads the report. The sample channel stays not ready until the
// report is loaded, also while an earlier report waits to be taken. Samples past MAX_SAMPLES in
// one waveform are dropped. Registers: 0 threshold, 1 min_gap, 2 cut_base, 3 cut_step.
module double_pulse_detector #(
    parameter int WINDOW      = dpd_pkg::WINDOW_DEF,
    parameter int SAMPLE_BITS = dpd_pkg::SAMPLE_BITS_DEF,
    parameter int MAX_SAMPLES = dpd_pkg::MAX_SAMPLES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    dpd_sample_if.sink                          samples,
    dpd_result_if.source                        results,
    input  logic                                cfg_we,
    input  logic [dpd_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [dpd_pkg::CFG_DATA_W-1:0]      cfg_data
);
    localparam int VW    = SAMPLE_BITS + 1;
    localparam int POS_W = $clog2(MAX_SAMPLES);
    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int FW    = $clog2(WINDOW);
    localparam int LW    = (VW > 14) ? VW : 14;

    typedef enum logic [3:0] {
        ST_RUN   = 4'b0001,
        ST_FLUSH = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [dpd_pkg::THRESHOLD_W-1:0] threshold_reg;
    logic [dpd_pkg::MIN_GAP_W-1:0]   min_gap_reg;
    logic [dpd_pkg::CUT_BASE_W-1:0]  cut_base_reg;
    logic [dpd_pkg::CUT_STEP_W-1:0]  cut_step_reg;
    dpd_pkg::judge_cfg_t             judge_cfg;

    logic [CNT_W-1:0] count_reg, count_next;
    logic [FW-1:0]    flush_reg, flush_next;
    logic             fresh_reg;

    logic             accept;
    logic             shift;
    logic             load;
    logic             clear;
    logic signed [VW-1:0] entry_value;
    logic             entry_valid;

    logic                 cell_valid [WINDOW];
    logic signed [VW-1:0] cell_value [WINDOW];
    logic signed [VW-1:0] cell_peak  [WINDOW];

    logic                 first_seen, second_seen;
    logic [POS_W-1:0]     first_pos, second_pos;
    logic signed [VW-1:0] first_peak, second_peak;

    logic [dpd_pkg::LEVEL_W-1:0] level;
    logic [LW-1:0]               cut_at;

    logic                          out_valid_reg;
    logic                          out_first_found_reg;
    logic                          out_second_found_reg;
    logic [dpd_pkg::IDX_W-1:0]     out_first_index_reg;
    logic [dpd_pkg::IDX_W-1:0]     out_second_index_reg;
    logic [dpd_pkg::IDX_W-1:0]     out_gap_reg;
    logic [dpd_pkg::HEIGHT_W-1:0]  out_first_height_reg;
    logic [dpd_pkg::HEIGHT_W-1:0]  out_second_height_reg;
    logic [dpd_pkg::LEVEL_W-1:0]   out_cut_level_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= dpd_pkg::THRESHOLD_RST;
            min_gap_reg   <= dpd_pkg::MIN_GAP_RST;
            cut_base_reg  <= dpd_pkg::CUT_BASE_RST;
            cut_step_reg  <= dpd_pkg::CUT_STEP_RST;
        end
        else if (cfg_we)
        begin
            unique case (dpd_pkg::cfg_index_t'(cfg_index))
                dpd_pkg::CFG_THRESHOLD: threshold_reg <= cfg_data[dpd_pkg::THRESHOLD_W-1:0];
                dpd_pkg::CFG_MIN_GAP:   min_gap_reg   <= cfg_data[dpd_pkg::MIN_GAP_W-1:0];
                dpd_pkg::CFG_CUT_BASE:  cut_base_reg  <= cfg_data[dpd_pkg::CUT_BASE_W-1:0];
                dpd_pkg::CFG_CUT_STEP:  cut_step_reg  <= cfg_data[dpd_pkg::CUT_STEP_W-1:0];
                default: ;
            endcase
        end
    end

    assign judge_cfg.threshold = threshold_reg;
    assign judge_cfg.min_gap   = min_gap_reg;

    // Sequencer
    assign samples.ready = (state_reg == ST_RUN);
    assign accept        = samples.valid && samples.ready;
    assign load          = (state_reg == ST_DONE) && (!out_valid_reg || results.ready);
    assign clear         = load;
    assign shift         = (accept && (count_reg < CNT_W'(MAX_SAMPLES)))
                           || (state_reg == ST_FLUSH);
    assign entry_valid   = (state_reg == ST_RUN);
    // Flush slots enter as zero so they never raise a peak.
    assign entry_value   = (state_reg == ST_RUN) ? -VW'(samples.sample) : '0;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        flush_next = flush_reg;
        unique case (state_reg)
            ST_RUN:
            begin
                if (accept && (count_reg < CNT_W'(MAX_SAMPLES)))
                begin
                    count_next = count_reg + 1'b1;
                end
                if (accept && samples.last_sample)
                begin
                    state_next = ST_FLUSH;
                    flush_next = '0;
                end
            end
            ST_FLUSH:
            begin
                flush_next = flush_reg + 1'b1;
                if (flush_reg == FW'(WINDOW - 2))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (load)
                begin
                    state_next = ST_RUN;
                    count_next = '0;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RUN;
            count_reg <= '0;
            flush_reg <= '0;
            fresh_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            flush_reg <= flush_next;
            fresh_reg <= shift;
        end
    end

    // Lookahead chain: cell 0 takes the newest value, the last cell holds the oldest.
    for (genvar i = 0; i < WINDOW; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            dpd_cell #(
                .SAMPLE_BITS (SAMPLE_BITS)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .shift       (shift),
                .clear       (clear),
                .entry_value (entry_value),
                .prev_valid  (entry_valid),
                .prev_value  (entry_value),
                .prev_peak   ('0),
                .valid       (cell_valid[i]),
                .value       (cell_value[i]),
                .peak        (cell_peak[i])
            );
        end
        else
        begin : g_body
            dpd_cell #(
                .SAMPLE_BITS (SAMPLE_BITS)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .shift       (shift),
                .clear       (clear),
                .entry_value (entry_value),
                .prev_valid  (cell_valid[i-1]),
                .prev_value  (cell_value[i-1]),
                .prev_peak   (cell_peak[i-1]),
                .valid       (cell_valid[i]),
                .value       (cell_value[i]),
                .peak        (cell_peak[i])
            );
        end
    end

    dpd_judge #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_judge (
        .clk         (clk),
        .rst_n       (rst_n),
        .clear       (clear),
        .fresh       (fresh_reg),
        .arr_valid   (cell_valid[WINDOW-1]),
        .arr_value   (cell_value[WINDOW-1]),
        .arr_peak    (cell_peak[WINDOW-1]),
        .cfg         (judge_cfg),
        .first_seen  (first_seen),
        .first_pos   (first_pos),
        .first_peak  (first_peak),
        .second_seen (second_seen),
        .second_pos  (second_pos),
        .second_peak (second_peak)
    );

    // Count the height cuts the second peak meets.
    always_comb
    begin
        level  = '0;
        cut_at = '0;
        for (int k = 0; k < dpd_pkg::CUT_LEVELS; k++)
        begin
            cut_at = LW'(cut_base_reg) + LW'(cut_step_reg) * LW'(k);
            if (second_seen && (LW'(second_peak) >= cut_at))
            begin
                level = level + 1'b1;
            end
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_first_found_reg   <= first_seen;
            out_second_found_reg  <= second_seen;
            out_first_index_reg   <= dpd_pkg::IDX_W'(first_pos);
            out_second_index_reg  <= dpd_pkg::IDX_W'(second_pos);
            out_gap_reg           <= second_seen ? dpd_pkg::IDX_W'(second_pos - first_pos) : '0;
            out_first_height_reg  <= dpd_pkg::HEIGHT_W'(first_peak);
            out_second_height_reg <= dpd_pkg::HEIGHT_W'(second_peak);
            out_cut_level_reg     <= level;
        end
    end

    assign results.valid         = out_valid_reg;
    assign results.first_found   = out_first_found_reg;
    assign results.second_found  = out_second_found_reg;
    assign results.first_index   = out_first_index_reg;
    assign results.second_index  = out_second_index_reg;
    assign results.gap_samples   = out_gap_reg;
    assign results.first_height  = out_first_height_reg;
    assign results.second_height = out_second_height_reg;
    assign results.cut_level     = out_cut_level_reg;

    // A second pulse is only ever reported together with a first one.
    a_second_needs_first : assert property (@(posedge clk) disable iff (!rst_n)
        results.valid |-> (!results.second_found || results.first_found))
        else $error("second pulse reported without a first pulse");

    // The gap agrees with the two reported positions.
    a_gap_consistent : assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.second_found)
            |-> (results.gap_samples == dpd_pkg::IDX_W'(results.second_index
                                                        - results.first_index)))
        else $error("gap does not match the reported positions");

    // No cut level without a second pulse, and never above the number of cuts.
    a_level_range : assert property (@(posedge clk) disable iff (!rst_n)
        results.valid |-> ((results.cut_level <= dpd_pkg::LEVEL_W'(dpd_pkg::CUT_LEVELS))
                           && (results.second_found || (results.cut_level == '0))))
        else $error("cut level out of range");

    // The end of a waveform closes the sample channel for the flush.
    a_last_closes_input : assert property (@(posedge clk) disable iff (!rst_n)
        (accept && samples.last_sample) |=> !samples.ready)
        else $error("sample taken during the end-of-waveform flush");
endmodule

// ===== hdl/dpd_cell.sv =====
// One cell of the lookahead chain: a pulse value and the running peak of it and what followed it.
module dpd_cell #(
    parameter int SAMPLE_BITS = dpd_pkg::SAMPLE_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        shift,
    input  logic                        clear,
    input  logic signed [SAMPLE_BITS:0] entry_value,
    input  logic                        prev_valid,
    input  logic signed [SAMPLE_BITS:0] prev_value,
    input  logic signed [SAMPLE_BITS:0] prev_peak,
    output logic                        valid,
    output logic signed [SAMPLE_BITS:0] value,
    output logic signed [SAMPLE_BITS:0] peak
);
    logic                        valid_reg;
    logic signed [SAMPLE_BITS:0] value_reg;
    logic signed [SAMPLE_BITS:0] peak_reg;
    logic signed [SAMPLE_BITS:0] peak_next;

    // Every cell sees the value entering the chain and folds it into its peak.
    assign peak_next = (entry_value > prev_peak) ? entry_value : prev_peak;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (clear)
        begin
            valid_reg <= 1'b0;
        end
        else if (shift)
        begin
            valid_reg <= prev_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            value_reg <= prev_value;
            peak_reg  <= peak_next;
        end
    end

    assign valid = valid_reg;
    assign value = value_reg;
    assign peak  = peak_reg;
endmodule

// ===== hdl/dpd_judge.sv =====
// Pulse judge at the end of the chain: records the first pulse and the later second pulse.
module dpd_judge #(
    parameter int SAMPLE_BITS = dpd_pkg::SAMPLE_BITS_DEF,
    parameter int MAX_SAMPLES = dpd_pkg::MAX_SAMPLES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              clear,
    input  logic                              fresh,
    input  logic                              arr_valid,
    input  logic signed [SAMPLE_BITS:0]       arr_value,
    input  logic signed [SAMPLE_BITS:0]       arr_peak,
    input  dpd_pkg::judge_cfg_t               cfg,
    output logic                              first_seen,
    output logic [$clog2(MAX_SAMPLES)-1:0]    first_pos,
    output logic signed [SAMPLE_BITS:0]       first_peak,
    output logic                              second_seen,
    output logic [$clog2(MAX_SAMPLES)-1:0]    second_pos,
    output logic signed [SAMPLE_BITS:0]       second_peak
);
    localparam int VW    = SAMPLE_BITS + 1;
    localparam int V2W   = VW + 1;
    localparam int POS_W = $clog2(MAX_SAMPLES);
    localparam int TW    = (V2W > dpd_pkg::THRESHOLD_W + 1) ? V2W : dpd_pkg::THRESHOLD_W + 1;
    localparam int CW    = (POS_W > dpd_pkg::MIN_GAP_W) ? POS_W : dpd_pkg::MIN_GAP_W;

    logic                     first_seen_reg, first_seen_next;
    logic                     second_seen_reg, second_seen_next;
    logic [POS_W-1:0]         pos_reg, pos_next;
    logic [POS_W-1:0]         first_pos_reg, first_pos_next;
    logic [POS_W-1:0]         second_pos_reg, second_pos_next;
    logic signed [VW-1:0]     first_peak_reg, first_peak_next;
    logic signed [VW-1:0]     second_peak_reg, second_peak_next;

    logic signed [V2W-1:0]    twice;
    logic signed [TW-1:0]     twice_ext;
    logic signed [TW-1:0]     thr_ext;
    logic [POS_W-1:0]         pos_gap;
    logic                     is_pulse;
    logic                     far_enough;

    always_comb
    begin
        twice      = $signed({arr_value, 1'b0});
        twice_ext  = TW'(twice);
        thr_ext    = $signed(TW'(cfg.threshold));
        pos_gap    = pos_reg - first_pos_reg;
        far_enough = CW'(pos_gap) > CW'(cfg.min_gap);
        is_pulse   = fresh && arr_valid && !second_seen_reg
                     && (twice_ext >= thr_ext) && (twice > V2W'(arr_peak));

        first_seen_next  = first_seen_reg;
        first_pos_next   = first_pos_reg;
        first_peak_next  = first_peak_reg;
        second_seen_next = second_seen_reg;
        second_pos_next  = second_pos_reg;
        second_peak_next = second_peak_reg;
        pos_next         = pos_reg;

        if (fresh && arr_valid)
        begin
            pos_next = pos_reg + 1'b1;
        end
        if (is_pulse && !first_seen_reg)
        begin
            first_seen_next = 1'b1;
            first_pos_next  = pos_reg;
            first_peak_next = arr_peak;
        end
        else if (is_pulse && far_enough)
        begin
            second_seen_next = 1'b1;
            second_pos_next  = pos_reg;
            second_peak_next = arr_peak;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_seen_reg  <= 1'b0;
            second_seen_reg <= 1'b0;
            pos_reg         <= '0;
            first_pos_reg   <= '0;
            second_pos_reg  <= '0;
            first_peak_reg  <= '0;
            second_peak_reg <= '0;
        end
        else if (clear)
        begin
            first_seen_reg  <= 1'b0;
            second_seen_reg <= 1'b0;
            pos_reg         <= '0;
            first_pos_reg   <= '0;
            second_pos_reg  <= '0;
            first_peak_reg  <= '0;
            second_peak_reg <= '0;
        end
        else
        begin
            first_seen_reg  <= first_seen_next;
            second_seen_reg <= second_seen_next;
            pos_reg         <= pos_next;
            first_pos_reg   <= first_pos_next;
            second_pos_reg  <= second_pos_next;
            first_peak_reg  <= first_peak_next;
            second_peak_reg <= second_peak_next;
        end
    end

    assign first_seen  = first_seen_reg;
    assign first_pos   = first_pos_reg;
    assign first_peak  = first_peak_reg;
    assign second_seen = second_seen_reg;
    assign second_pos  = second_pos_reg;
    assign second_peak = second_peak_reg;
endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench of the double pulse detector against a pulse-pair predictor.
module tb_top;
    import dpd_pkg::*;

    localparam int SETTLE_CYCLES  = WINDOW_DEF + 8;
    localparam int LONG_HOLD      = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_SAMPLES = 860;

    typedef struct packed {
        logic signed [SAMPLE_BITS_DEF-1:0] sample;
        logic                              last_flag;
    } sample_item_t;

    typedef struct packed {
        logic                first_found;
        logic                second_found;
        logic [IDX_W-1:0]    first_index;
        logic [IDX_W-1:0]    second_index;
        logic [IDX_W-1:0]    gap_samples;
        logic [HEIGHT_W-1:0] first_height;
        logic [HEIGHT_W-1:0] second_height;
        logic [LEVEL_W-1:0]  cut_level;
    } pulse_report_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_THRESHOLD;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    dpd_sample_if samples_if ();
    dpd_result_if results_if ();

    double_pulse_detector uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (samples_if),
        .results   (results_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Predictor state: register copies and the waveform being scanned
    int  thr_reg;
    int  gap_reg;
    int  base_reg;
    int  step_reg;
    int  pulse_win [WINDOW_DEF];
    int  n_seen;
    bit  first_hit;
    bit  second_hit;
    int  first_at;
    int  second_at;
    int  first_pk;
    int  second_pk;

    sample_item_t  pending_samples [$];
    pulse_report_t pending_reports [$];

    bit sample_taken = 1'b0;
    int send_gap = 0;
    int stall_left = 0;
    int hold_left = 0;
    int hold_requests = 0;
    int holds_served = 0;
    bit idle_off = 1'b0;
    int quiet_cycles = 0;

    int errors = 0;
    int samples_accepted = 0;
    int reports_checked = 0;
    int pair_reports = 0;
    int settings_written = 0;

    function automatic void clear_waveform_state();
        foreach (pulse_win[i])
            pulse_win[i] = 0;
        n_seen = 0;
        first_hit = 1'b0;
        second_hit = 1'b0;
        first_at = 0;
        second_at = 0;
        first_pk = 0;
        second_pk = 0;
    endfunction

    // Positions past the end of the waveform read as zero
    function automatic int value_at(input int q);
        return (q >= n_seen) ? 0 : pulse_win[q % WINDOW_DEF];
    endfunction

    function automatic void judge_position(input int p);
        int v;
        int pk;
        int j;
        if (second_hit)
            return;
        v = value_at(p);
        if (2 * v < thr_reg)
            return;
        pk = 0;
        for (j = 0; j < WINDOW_DEF; j++)
            if (value_at(p + j) > pk)
                pk = value_at(p + j);
        if (!(2 * v > pk))
            return;
        if (!first_hit)
        begin
            first_hit = 1'b1;
            first_at = p;
            first_pk = pk;
        end
        else if (p - first_at > gap_reg)
        begin
            second_hit = 1'b1;
            second_at = p;
            second_pk = pk;
        end
    endfunction

    // Advance the pulse search by one sample; return 1 with the report on the final sample
    function automatic bit detect_step(input logic signed [SAMPLE_BITS_DEF-1:0] s,
                                       input logic last_flag, output pulse_report_t rep);
        int lo;
        int p;
        int k;
        int lvl;
        rep = '0;
        if (n_seen < MAX_SAMPLES_DEF)
        begin
            pulse_win[n_seen % WINDOW_DEF] = -int'(s);
            n_seen++;
            if (n_seen >= WINDOW_DEF)
                judge_position(n_seen - WINDOW_DEF);
        end
        if (!last_flag)
            return 1'b0;
        lo = (n_seen >= WINDOW_DEF) ? n_seen - WINDOW_DEF + 1 : 0;
        for (p = lo; p < n_seen; p++)
            judge_position(p);
        lvl = 0;
        if (second_hit)
            for (k = 0; k < CUT_LEVELS; k++)
                if (second_pk >= base_reg + k * step_reg)
                    lvl++;
        rep.first_found   = first_hit;
        rep.second_found  = second_hit;
        rep.first_index   = first_hit ? IDX_W'(first_at) : '0;
        rep.second_index  = second_hit ? IDX_W'(second_at) : '0;
        rep.gap_samples   = second_hit ? IDX_W'(second_at - first_at) : '0;
        rep.first_height  = first_hit ? HEIGHT_W'(first_pk) : '0;
        rep.second_height = second_hit ? HEIGHT_W'(second_pk) : '0;
        rep.cut_level     = LEVEL_W'(lvl);
        clear_waveform_state();
        return 1'b1;
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int draw_gap();
        int r;
        if (idle_off)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic void push_sample(input int s, input bit last_flag);
        sample_item_t it;
        it.sample = SAMPLE_BITS_DEF'(s);
        it.last_flag = last_flag;
        pending_samples.push_back(it);
    endfunction

    // Build one waveform: full-range noise, quiet junk, or baseline noise with pulses
    function automatic int queue_waveform(input int len);
        int wav [];
        int kind;
        int n;
        int pos;
        int amp;
        int r;
        wav = new[len];
        kind = $urandom_range(0, 99);
        if (kind < 15)
        begin
            foreach (wav[i])
                wav[i] = int'($urandom_range(0, 4095)) - 2048;
        end
        else
        begin
            n = (kind < 25) ? 10 : $urandom_range(0, 8);
            foreach (wav[i])
                wav[i] = int'($urandom_range(0, 2 * n)) - n;
            if (kind >= 25)
            begin
                repeat ($urandom_range(1, 4))
                begin
                    pos = $urandom_range(0, len - 1);
                    r = $urandom_range(0, 99);
                    amp = (r < 75) ? $urandom_range(10, 300) :
                          (r < 95) ? $urandom_range(300, 2047) : 2048;
                    wav[pos] -= amp;
                    if (pos + 1 < len)
                        wav[pos + 1] -= amp / 2;
                    if (pos + 2 < len)
                        wav[pos + 2] -= amp / 4;
                end
            end
        end
        foreach (wav[i])
            push_sample((wav[i] < -2048) ? -2048 : (wav[i] > 2047) ? 2047 : wav[i],
                        i == len - 1);
        return len;
    endfunction

    function automatic void show_field(input string name, input logic [15:0] want,
                                       input logic [15:0] got);
        if (got !== want)
            $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
    endfunction

    task automatic write_reg(input cfg_index_t idx, input int unsigned value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_DATA_W'(value);
        @(posedge clk);
    endtask

    task automatic write_settings(input int unsigned thr, input int unsigned gap,
                                  input int unsigned base, input int unsigned step);
        write_reg(CFG_THRESHOLD, thr);
        write_reg(CFG_MIN_GAP, gap);
        write_reg(CFG_CUT_BASE, base);
        write_reg(CFG_CUT_STEP, step);
        @(negedge clk);
        cfg_we <= 1'b0;
        thr_reg = int'(THRESHOLD_W'(thr));
        gap_reg = int'(MIN_GAP_W'(gap));
        base_reg = int'(CUT_BASE_W'(base));
        step_reg = int'(CUT_STEP_W'(step));
        settings_written++;
    endtask

    // Hold the sender until every report is in, then let the flush settle
    task automatic drain();
        while (pending_samples.size() != 0 || samples_if.valid || pending_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    always @(negedge clk)
    begin
        sample_item_t it;
        if (!rst_n)
        begin
            samples_if.valid <= 1'b0;
            samples_if.sample <= '0;
            samples_if.last_sample <= 1'b0;
        end
        else if (!samples_if.valid || sample_taken)
        begin
            if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
                samples_if.valid <= 1'b0;
            end
            else if (pending_samples.size() != 0)
            begin
                it = pending_samples.pop_front();
                samples_if.valid <= 1'b1;
                samples_if.sample <= it.sample;
                samples_if.last_sample <= it.last_flag;
                send_gap <= draw_gap();
            end
            else
            begin
                samples_if.valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            results_if.ready <= 1'b0;
        end
        else if (holds_served != hold_requests)
        begin
            holds_served <= hold_requests;
            hold_left <= LONG_HOLD;
            results_if.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            results_if.ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            results_if.ready <= 1'b0;
        end
        else
        begin
            results_if.ready <= 1'b1;
            stall_left <= draw_gap();
        end
    end

    always @(posedge clk)
    begin
        pulse_report_t made;
        pulse_report_t want;
        pulse_report_t got;
        bit moved;
        sample_taken <= samples_if.valid && samples_if.ready;
        moved = 1'b0;
        if (rst_n)
        begin
            if (samples_if.valid && samples_if.ready)
            begin
                moved = 1'b1;
                samples_accepted++;
                if (detect_step(samples_if.sample, samples_if.last_sample, made))
                    pending_reports.push_back(made);
            end
            if (results_if.valid && results_if.ready)
            begin
                moved = 1'b1;
                got = {results_if.first_found, results_if.second_found,
                       results_if.first_index, results_if.second_index,
                       results_if.gap_samples, results_if.first_height,
                       results_if.second_height, results_if.cut_level};
                if (pending_reports.size() == 0)
                begin
                    errors++;
                    if (errors <= 20)
                        $display("%0t: report with none expected, actual %h", $time, got);
                end
                else
                begin
                    want = pending_reports.pop_front();
                    reports_checked++;
                    if (want.second_found)
                        pair_reports++;
                    if (got !== want)
                    begin
                        errors++;
                        if (errors <= 20)
                        begin
                            show_field("first_found", 16'(want.first_found),
                                       16'(got.first_found));
                            show_field("second_found", 16'(want.second_found),
                                       16'(got.second_found));
                            show_field("first_index", 16'(want.first_index),
                                       16'(got.first_index));
                            show_field("second_index", 16'(want.second_index),
                                       16'(got.second_index));
                            show_field("gap_samples", 16'(want.gap_samples),
                                       16'(got.gap_samples));
                            show_field("first_height", 16'(want.first_height),
                                       16'(got.first_height));
                            show_field("second_height", 16'(want.second_height),
                                       16'(got.second_height));
                            show_field("cut_level", 16'(want.cut_level),
                                       16'(got.cut_level));
                        end
                    end
                end
            end
        end
        quiet_cycles <= moved ? 0 : quiet_cycles + 1;
    end

    always @(posedge clk)
    begin
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        int random_samples;
        int phase;
        thr_reg = int'(THRESHOLD_RST);
        gap_reg = int'(MIN_GAP_RST);
        base_reg = int'(CUT_BASE_RST);
        step_reg = int'(CUT_STEP_RST);
        clear_waveform_state();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: full-scale pulse at sample 0, full-scale positive, pulse right at threshold
        push_sample(-2048, 1'b1);
        push_sample(2047, 1'b1);
        push_sample(-20, 1'b1);
        drain();

        write_settings(40, 3, 20, 5);
        // Second pulse at top cut level, later candidate ignored
        push_sample(-30, 1'b0);
        repeat (4) push_sample(0, 1'b0);
        push_sample(-25, 1'b0);
        push_sample(-10, 1'b0);
        push_sample(-40, 1'b1);
        // Candidate exactly min_gap after the first is skipped
        push_sample(-30, 1'b0);
        push_sample(0, 1'b0);
        push_sample(0, 1'b0);
        push_sample(-30, 1'b0);
        push_sample(0, 1'b0);
        push_sample(-30, 1'b1);
        // Larger value in the lookahead window suppresses the earlier position
        push_sample(-30, 1'b0);
        push_sample(-70, 1'b1);
        drain();

        // Stall the result side while short waveforms pile up behind it
        write_settings(30, 2, 25, 10);
        @(posedge clk);
        hold_requests = hold_requests + 1;
        repeat (10) void'(queue_waveform($urandom_range(2, 8)));
        drain();

        random_samples = 0;
        phase = 0;
        while (random_samples < RANDOM_SAMPLES)
        begin
            case (phase)
                0: write_settings(0, 0, 0, 0);
                1: write_settings(4096, 4095, 2048, 512);
                default: write_settings(
                    ($urandom_range(0, 9) < 7) ? $urandom_range(0, 150) : $urandom_range(0, 4096),
                    ($urandom_range(0, 9) < 8) ? $urandom_range(0, 40) : $urandom_range(0, 4095),
                    ($urandom_range(0, 9) < 8) ? $urandom_range(0, 400) : $urandom_range(0, 2048),
                    ($urandom_range(0, 9) < 8) ? $urandom_range(0, 100) : $urandom_range(0, 512));
            endcase
            idle_off = (phase % 4 == 3);
            repeat ($urandom_range(3, 6))
            begin
                if (random_samples < RANDOM_SAMPLES)
                    random_samples += queue_waveform(($urandom_range(0, 99) < 85) ?
                                                     $urandom_range(1, 40) :
                                                     $urandom_range(41, 250));
            end
            drain();
            phase++;
        end

        errors += pending_reports.size();
        $display("Run covered %0d samples in %0d checked reports under %0d register settings,",
                 samples_accepted, reports_checked, settings_written);
        $display("including a long result stall and back-to-back waveforms; %0d had pairs.",
                 pair_reports);
        if (errors == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/dpd_pkg.sv
hdl/dpd_sample_if.sv
hdl/dpd_result_if.sv
hdl/dpd_cell.sv
hdl/dpd_judge.sv
hdl/double_pulse_detector.sv
test/tb_top.sv
